@@ sv/ssms_pkg.sv @@
package ssms_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int MAX_SAMPLES = 64;
	localparam int COUNT_OUT_W = 7;

	// accumulator widths follow from the sample limit
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = SAMPLE_W + CNT_W;
	localparam int PROD_W = 2 * SAMPLE_W;
	localparam int SQ_W   = PROD_W - 1 + CNT_W;
	localparam int NUM_W  = SQ_W + CNT_W;
	localparam int DVS_W  = 2 * CNT_W;
	localparam int DIT_W  = $clog2(NUM_W);

	// variance never exceeds a quarter of the squared full range
	localparam int VAR_W  = 2 * SAMPLE_W;
	localparam int ROOT_W = VAR_W / 2;
	localparam int SIT_W  = $clog2(ROOT_W);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QLVL_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic signed [SUM_W-1:0]    sum;
		logic [SQ_W-1:0]            sumsq;
		logic [CNT_W-1:0]           cnt;
		logic signed [SAMPLE_W-1:0] lo;
		logic signed [SAMPLE_W-1:0] hi;
		logic                       dropped;
	} stats_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_LOAD,
		B_MUL,
		B_SUB,
		B_DVS,
		B_DVW,
		B_DMS,
		B_DMW,
		B_SQRT,
		B_EMIT
	} back_state_t;

endpackage

@@ sv/ssms_front.sv @@
module ssms_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [ssms_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 missing,
	input  logic                                 last,
	input  logic [ssms_pkg::QLVL_W-1:0]          level,
	output logic                                 busy,
	output logic                                 push,
	output ssms_pkg::stats_t                     push_data
);
	import ssms_pkg::*;

	logic                       v_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       miss_s1;
	logic                       last_s1;
	logic [PROD_W-1:0]          sq_s1;

	logic [SAMPLE_W-1:0] mag;
	logic                accept;
	stats_t              acc_q;
	stats_t              acc_nxt;
	logic                first;
	logic [QLVL_W:0]     pending;

	assign accept = start && !busy;
	assign mag    = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;

	// a set closing in the register stage still needs a queue slot
	assign pending = {1'b0, level} + (QLVL_W+1)'(v_s1 && last_s1);
	assign busy    = pending >= (QLVL_W+1)'(QDEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			miss_s1   <= missing;
			last_s1   <= last;
			sq_s1     <= PROD_W'(mag) * PROD_W'(mag);
		end
	end

	assign first = (acc_q.cnt == '0);

	always_comb begin
		acc_nxt = acc_q;
		if (!miss_s1) begin
			if (acc_q.cnt >= CNT_W'(MAX_SAMPLES)) begin
				acc_nxt.dropped = 1'b1;
			end else begin
				acc_nxt.sum   = acc_q.sum + SUM_W'(sample_s1);
				acc_nxt.sumsq = acc_q.sumsq + SQ_W'(sq_s1);
				acc_nxt.cnt   = acc_q.cnt + 1'b1;
				if (first || sample_s1 < acc_q.lo) begin
					acc_nxt.lo = sample_s1;
				end
				if (first || sample_s1 > acc_q.hi) begin
					acc_nxt.hi = sample_s1;
				end
			end
		end
	end

	assign push      = v_s1 && last_s1;
	assign push_data = acc_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (v_s1) begin
			// clear after handing the closed set to the back end
			acc_q <= last_s1 ? '0 : acc_nxt;
		end
	end

endmodule

@@ sv/ssms_fifo.sv @@
module ssms_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  ssms_pkg::stats_t            push_data,
	input  logic                        pop,
	output logic                        not_empty,
	output logic [ssms_pkg::QLVL_W-1:0] level,
	output ssms_pkg::stats_t            pop_data
);
	import ssms_pkg::*;

	stats_t            slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QLVL_W-1:0] lvl_q;
	logic              do_pop;

	assign do_pop    = pop && (lvl_q != '0);
	assign not_empty = (lvl_q != '0);
	assign level     = lvl_q;
	assign pop_data  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			lvl_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   lvl_q <= lvl_q + 1'b1;
				2'b01:   lvl_q <= lvl_q - 1'b1;
				default: lvl_q <= lvl_q;
			endcase
		end
	end

endmodule

@@ sv/ssms_div.sv @@
module ssms_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ssms_pkg::NUM_W-1:0] dividend,
	input  logic [ssms_pkg::DVS_W-1:0] divisor,
	output logic                       done,
	output logic [ssms_pkg::NUM_W-1:0] quotient
);
	import ssms_pkg::*;

	logic             run_q;
	logic             done_q;
	logic [DIT_W-1:0] it_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DVS_W:0]   rem_sh;
	logic             ge;

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				it_q  <= '0;
			end else if (run_q) begin
				it_q <= it_q + 1'b1;
				if (it_q == DIT_W'(NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ sv/ssms_back.sv @@
module ssms_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  not_empty,
	input  ssms_pkg::stats_t                      pop_data,
	output logic                                  pop,
	output logic                                  done,
	output logic signed [ssms_pkg::SAMPLE_W-1:0]  mean,
	output logic [ssms_pkg::ROOT_W-1:0]           std_dev,
	output logic [ssms_pkg::SAMPLE_W-1:0]         spread,
	output logic [ssms_pkg::COUNT_OUT_W-1:0]      valid_count,
	output logic                                  empty_res,
	output logic                                  overflowed
);
	import ssms_pkg::*;

	back_state_t state_q;
	back_state_t state_nxt;

	stats_t              ent_q;
	logic [SAMPLE_W-1:0] spread_q;
	logic [SUM_W-1:0]    sum_mag_q;
	logic                sum_neg_q;
	logic [NUM_W-1:0]    prod_a_q;
	logic [NUM_W-1:0]    prod_b_q;
	logic [DVS_W-1:0]    nn_q;
	logic [NUM_W-1:0]    num_q;
	logic [SAMPLE_W-1:0] mean_q;

	logic [VAR_W-1:0]    rad_q;
	logic [ROOT_W+1:0]   srem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [SIT_W-1:0]    sit_q;
	logic [ROOT_W+1:0]   srem_n;
	logic [ROOT_W+1:0]   trial;
	logic                sq_ge;

	logic             div_start;
	logic             div_mean;
	logic [NUM_W-1:0] div_dividend;
	logic [DVS_W-1:0] div_divisor;
	logic             div_done;
	logic [NUM_W-1:0] div_quo;

	assign div_dividend = div_mean ? NUM_W'(sum_mag_q) : num_q;
	assign div_divisor  = div_mean ? DVS_W'(ent_q.cnt) : nn_q;

	ssms_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			B_IDLE: if (not_empty) state_nxt = B_LOAD;
			B_LOAD: state_nxt = (ent_q.cnt == '0) ? B_EMIT : B_MUL;
			B_MUL:  state_nxt = B_SUB;
			B_SUB:  state_nxt = B_DVS;
			B_DVS:  state_nxt = B_DVW;
			B_DVW:  if (div_done) state_nxt = B_DMS;
			B_DMS:  state_nxt = B_DMW;
			B_DMW:  if (div_done) state_nxt = B_SQRT;
			B_SQRT: if (sit_q == SIT_W'(ROOT_W - 1)) state_nxt = B_EMIT;
			B_EMIT: state_nxt = B_IDLE;
			default: state_nxt = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop       = 1'b0;
		div_start = 1'b0;
		div_mean  = 1'b0;
		done      = 1'b0;
		unique case (state_q)
			B_IDLE: pop = not_empty;
			B_DVS:  div_start = 1'b1;
			B_DMS: begin
				div_start = 1'b1;
				div_mean  = 1'b1;
			end
			B_EMIT: done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// floor square root, two radicand bits per step
	assign srem_n = {srem_q[ROOT_W-1:0], rad_q[VAR_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign sq_ge  = srem_n >= trial;

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (not_empty) begin
					ent_q <= pop_data;
				end
			end
			B_LOAD: begin
				spread_q  <= ent_q.hi - ent_q.lo;
				sum_neg_q <= ent_q.sum[SUM_W-1];
				sum_mag_q <= ent_q.sum[SUM_W-1] ? (~ent_q.sum + 1'b1) : ent_q.sum;
				mean_q    <= '0;
				root_q    <= '0;
			end
			B_MUL: begin
				prod_a_q <= NUM_W'(ent_q.cnt) * NUM_W'(ent_q.sumsq);
				prod_b_q <= NUM_W'(sum_mag_q) * NUM_W'(sum_mag_q);
				nn_q     <= DVS_W'(ent_q.cnt) * DVS_W'(ent_q.cnt);
			end
			B_SUB: begin
				num_q <= prod_a_q - prod_b_q;
			end
			B_DVW: begin
				if (div_done) begin
					rad_q  <= div_quo[VAR_W-1:0];
					srem_q <= '0;
					root_q <= '0;
					sit_q  <= '0;
				end
			end
			B_DMW: begin
				if (div_done) begin
					mean_q <= sum_neg_q ? (~div_quo[SAMPLE_W-1:0] + 1'b1)
					                    : div_quo[SAMPLE_W-1:0];
				end
			end
			B_SQRT: begin
				srem_q <= sq_ge ? (srem_n - trial) : srem_n;
				root_q <= {root_q[ROOT_W-2:0], sq_ge};
				rad_q  <= {rad_q[VAR_W-3:0], 2'b00};
				sit_q  <= sit_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign mean        = mean_q;
	assign std_dev     = root_q;
	assign spread      = spread_q;
	assign valid_count = COUNT_OUT_W'(ent_q.cnt);
	assign empty_res   = (ent_q.cnt == '0);
	assign overflowed  = ent_q.dropped;

endmodule

@@ sv/sample_set_mean_stddev_spread.sv @@
// Channel   Handshake          Signals
// -------   ----------------   ------------------------------------------------
// reading   start / busy       sample[23:0] s, missing, last
// result    done (1 cycle)     mean[23:0] s, std_dev[23:0], spread[23:0],
//                              valid_count[6:0], empty_res, overflowed
//
// Readings are taken one per cycle while busy is low; the accumulators update in the cycle after.
// A closed set goes to a two-entry queue; the back end then takes each set from
// pop to result one at a time through its shared bit-serial divider (variance,
// then mean) and the 24-step square root.
// busy rises while the queue holds two closed sets, or one while another closes.
// arst_n clears the accumulators, the queue and the sequencer at once.
// done marks each result for exactly one cycle; the receiver cannot stall it.
module sample_set_mean_stddev_spread (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [ssms_pkg::SAMPLE_W-1:0]    sample,
	input  logic                                    missing,
	input  logic                                    last,
	output logic                                    done,
	output logic signed [ssms_pkg::SAMPLE_W-1:0]    mean,
	output logic [ssms_pkg::ROOT_W-1:0]             std_dev,
	output logic [ssms_pkg::SAMPLE_W-1:0]           spread,
	output logic [ssms_pkg::COUNT_OUT_W-1:0]        valid_count,
	output logic                                    empty_res,
	output logic                                    overflowed
);
	import ssms_pkg::*;

	logic              push;
	stats_t            push_data;
	logic              pop;
	logic              not_empty;
	logic [QLVL_W-1:0] level;
	stats_t            pop_data;

	ssms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sample    (sample),
		.missing   (missing),
		.last      (last),
		.level     (level),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	ssms_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.not_empty (not_empty),
		.level     (level),
		.pop_data  (pop_data)
	);

	ssms_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.not_empty   (not_empty),
		.pop_data    (pop_data),
		.pop         (pop),
		.done        (done),
		.mean        (mean),
		.std_dev     (std_dev),
		.spread      (spread),
		.valid_count (valid_count),
		.empty_res   (empty_res),
		.overflowed  (overflowed)
	);

endmodule

@@ sv/ssms_chk.sv @@
module ssms_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 done,
	input logic signed [ssms_pkg::SAMPLE_W-1:0] mean,
	input logic [ssms_pkg::ROOT_W-1:0]          std_dev,
	input logic [ssms_pkg::SAMPLE_W-1:0]        spread,
	input logic [ssms_pkg::COUNT_OUT_W-1:0]     valid_count,
	input logic                                 empty_res
);

	// results are spaced apart by the back-end sequence
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && empty_res |-> mean == '0 && std_dev == '0 && spread == '0
			&& valid_count == '0)
		else $error("empty set result not zero");

	// deviation never exceeds the spread
	a_dev_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> {1'b0, std_dev} <= {1'b0, spread})
		else $error("deviation larger than spread");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		done && !empty_res && valid_count == 7'd1 |-> std_dev == '0 && spread == '0)
		else $error("single reading with nonzero deviation or spread");

endmodule

bind sample_set_mean_stddev_spread ssms_chk u_ssms_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.done        (done),
	.mean        (mean),
	.std_dev     (std_dev),
	.spread      (spread),
	.valid_count (valid_count),
	.empty_res   (empty_res)
);
